// ===== sv/bms_pkg.sv =====
// Shared types and constants for the beeper melody sequencer.
// Holds the port item types, the action codes and the queued command format.
// No dependencies.
package bms_pkg;

    // Action codes carried in the input item.
    localparam logic [1:0] ACT_TICK   = 2'd0;
    localparam logic [1:0] ACT_NOTE   = 2'd1;
    localparam logic [1:0] ACT_SCORE  = 2'd2;
    localparam logic [1:0] ACT_DIRECT = 2'd3;

    // Modulus applied to the gain of a direct play.
    localparam logic [7:0] GAIN_MOD = 8'd101;

    // Entries in the queue between the front and the player.
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  note_address;
        logic [15:0] tone;
        logic [15:0] duration;
        logic [8:0]  note_count;
        logic [7:0]  gain;
    } item_t;

    typedef struct packed {
        logic        beeper_on;
        logic [15:0] out_tone;
        logic [7:0]  out_gain;
    } result_t;

    // Classified command as held in the queue.
    typedef enum logic [1:0] {
        K_TICK,
        K_NOTE,
        K_SCORE,
        K_DIRECT
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  note_address;
        logic [15:0] tone;
        logic [15:0] duration;
        logic [8:0]  note_count;
        logic [7:0]  gain;
    } cmd_t;

endpackage

// ===== sv/bms_front.sv =====
// Front end of the beeper melody sequencer: accepts items and classifies them.
// Drops items that cannot have an effect and reduces direct-play gain.
// Depends on bms_pkg.
module bms_front (
    input  logic           start,
    input  bms_pkg::item_t cmd,
    input  logic [15:0]    tick_step,
    input  logic           queue_full,
    output logic           busy,
    output logic           push,
    output bms_pkg::cmd_t  push_cmd
);
    import bms_pkg::*;

    logic       accept;
    logic       keep;
    logic [7:0] gain_red;

    assign busy   = queue_full;
    assign accept = start && !queue_full;

    // gain mod 101 for an 8-bit value: at most two subtractions
    always_comb
    begin
        if (cmd.gain >= 8'(2 * GAIN_MOD))
            gain_red = cmd.gain - 8'(2 * GAIN_MOD);
        else if (cmd.gain >= GAIN_MOD)
            gain_red = cmd.gain - GAIN_MOD;
        else
            gain_red = cmd.gain;
    end

    always_comb
    begin
        push_cmd.note_address = cmd.note_address;
        push_cmd.tone         = cmd.tone;
        push_cmd.duration     = cmd.duration;
        push_cmd.note_count   = cmd.note_count;
        push_cmd.gain         = cmd.gain;
        keep                  = 1'b1;
        unique case (cmd.action)
            ACT_NOTE:
            begin
                push_cmd.kind = K_NOTE;
            end
            ACT_SCORE:
            begin
                // drop an empty score
                push_cmd.kind = K_SCORE;
                keep          = (cmd.note_count != 9'd0);
            end
            ACT_DIRECT:
            begin
                push_cmd.kind = K_DIRECT;
                push_cmd.gain = gain_red;
            end
            default:
            begin
                // drop ticks while the player is disabled
                push_cmd.kind = K_TICK;
                keep          = (tick_step != 16'd0);
            end
        endcase
    end

    assign push = accept && keep;

endmodule

// ===== sv/bms_cmd_fifo.sv =====
// Short command queue between the front end and the player.
// Holds classified commands in order; full and empty flags for both sides.
// Depends on bms_pkg.
module bms_cmd_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  bms_pkg::cmd_t push_cmd,
    input  logic          pop,
    output bms_pkg::cmd_t head,
    output logic          full,
    output logic          empty
);
    import bms_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    cmd_t          entry_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] fill_reg;
    logic [CW-1:0] fill_next;
    logic          do_push;
    logic          do_pop;

    assign full    = (fill_reg == CW'(QUEUE_DEPTH));
    assign empty   = (fill_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            fill_next = fill_reg + 1'b1;
        else if (do_pop && !do_push)
            fill_next = fill_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

// ===== sv/bms_player.sv =====
// Back end of the beeper melody sequencer: note memory, score queue and player.
// Takes commands from the queue one at a time and drives the result strobe.
// Depends on bms_pkg.
module bms_player #(
    parameter int SCORE_SLOTS = 8,
    parameter int NOTE_DEPTH  = 256
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [15:0]      tick_step,
    input  bms_pkg::cmd_t    head,
    input  logic             empty,
    output logic             pop,
    output logic             result_valid,
    output bms_pkg::result_t result
);
    import bms_pkg::*;

    localparam int AW   = $clog2(NOTE_DEPTH);
    localparam int SUMW = (AW > 10) ? AW : 10;
    localparam int SW   = $clog2(SCORE_SLOTS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FIRST,
        ST_SECOND
    } state_t;

    typedef struct packed {
        logic [7:0] addr;
        logic [8:0] count;
        logic [7:0] gain;
    } slot_t;

    logic [31:0]   note_mem [NOTE_DEPTH];
    logic [31:0]   rd_data_reg;
    slot_t         slot_mem [SCORE_SLOTS];

    state_t        state_reg,   state_next;
    logic [SW-1:0] wr_slot_reg, wr_slot_next;
    logic [SW-1:0] rd_slot_reg, rd_slot_next;
    logic [7:0]    addr_reg,    addr_next;
    logic [8:0]    idx_reg,     idx_next;
    logic [8:0]    count_reg,   count_next;
    logic [15:0]   elapsed_reg, elapsed_next;
    logic [7:0]    gain_reg,    gain_next;
    logic          res_valid_reg, res_valid_next;
    result_t       res_reg,     res_next;

    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          note_we;
    logic          slot_we;
    logic [8:0]    idx_adv;
    logic [16:0]   elapsed_sum;
    slot_t         rd_slot;

    function automatic logic [AW-1:0] note_index(input logic [7:0] base,
                                                 input logic [8:0] offs);
        logic [SUMW-1:0] sum;
        begin
            sum        = SUMW'(base) + SUMW'(offs);
            note_index = sum[AW-1:0];
        end
    endfunction

    assign idx_adv     = idx_reg + 9'd1;
    assign elapsed_sum = {1'b0, elapsed_reg} + {1'b0, tick_step};
    assign rd_slot     = slot_mem[rd_slot_reg];

    always_comb
    begin
        state_next     = state_reg;
        wr_slot_next   = wr_slot_reg;
        rd_slot_next   = rd_slot_reg;
        addr_next      = addr_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        elapsed_next   = elapsed_reg;
        gain_next      = gain_reg;
        res_valid_next = 1'b0;
        res_next       = res_reg;
        rd_en          = 1'b0;
        rd_addr        = note_index(addr_reg, idx_reg);
        note_we        = 1'b0;
        slot_we        = 1'b0;
        pop            = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!empty)
                begin
                    pop = 1'b1;
                    unique case (head.kind)
                        K_NOTE:
                        begin
                            note_we = 1'b1;
                        end
                        K_SCORE:
                        begin
                            // stick at the last slot once the queue is full
                            slot_we = 1'b1;
                            if (wr_slot_reg < SW'(SCORE_SLOTS - 1))
                                wr_slot_next = wr_slot_reg + 1'b1;
                        end
                        K_DIRECT:
                        begin
                            res_valid_next = 1'b1;
                            res_next       = '{1'b1, head.tone, head.gain};
                        end
                        default:
                        begin
                            if (idx_reg < count_reg)
                            begin
                                // fetch the current note, decide next cycle
                                rd_en      = 1'b1;
                                state_next = ST_FIRST;
                            end
                            else
                            begin
                                // score finished: load the next one or rewind
                                idx_next       = '0;
                                count_next     = '0;
                                elapsed_next   = '0;
                                gain_next      = '0;
                                res_valid_next = 1'b1;
                                res_next       = '0;
                                if (rd_slot_reg >= wr_slot_reg)
                                begin
                                    rd_slot_next = '0;
                                    wr_slot_next = '0;
                                end
                                else
                                begin
                                    addr_next    = rd_slot.addr;
                                    count_next   = rd_slot.count;
                                    gain_next    = rd_slot.gain;
                                    rd_slot_next = rd_slot_reg + 1'b1;
                                end
                            end
                        end
                    endcase
                end
            end
            ST_FIRST:
            begin
                if (elapsed_reg >= rd_data_reg[31:16])
                begin
                    idx_next     = idx_adv;
                    elapsed_next = '0;
                    if (idx_adv < count_reg)
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = note_index(addr_reg, idx_adv);
                        state_next = ST_SECOND;
                    end
                    else
                    begin
                        res_valid_next = 1'b1;
                        res_next       = '0;
                        state_next     = ST_IDLE;
                    end
                end
                else
                begin
                    elapsed_next   = elapsed_sum[16] ? 16'hFFFF : elapsed_sum[15:0];
                    res_valid_next = 1'b1;
                    res_next       = '{1'b1, rd_data_reg[15:0], gain_reg};
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                // fresh note: timer restarts from zero plus one step
                elapsed_next   = tick_step;
                res_valid_next = 1'b1;
                res_next       = '{1'b1, rd_data_reg[15:0], gain_reg};
                state_next     = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wr_slot_reg   <= '0;
            rd_slot_reg   <= '0;
            addr_reg      <= '0;
            idx_reg       <= '0;
            count_reg     <= '0;
            elapsed_reg   <= '0;
            gain_reg      <= '0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            wr_slot_reg   <= wr_slot_next;
            rd_slot_reg   <= rd_slot_next;
            addr_reg      <= addr_next;
            idx_reg       <= idx_next;
            count_reg     <= count_next;
            elapsed_reg   <= elapsed_next;
            gain_reg      <= gain_next;
            res_valid_reg <= res_valid_next;
            res_reg       <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (note_we)
            note_mem[AW'(head.note_address)] <= {head.duration, head.tone};
        if (rd_en)
            rd_data_reg <= note_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (slot_we)
            slot_mem[wr_slot_reg] <= '{head.note_address, head.note_count, head.gain};
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

// ===== sv/beeper_melody_sequencer_unit.sv =====
// Top level of the beeper melody sequencer.
// Joins the front end, the command queue and the player; holds tick_step.
// Depends on bms_pkg, bms_front, bms_cmd_fifo and bms_player.
//
// Plays queued melodies on a beeper. An item is taken at a rising edge with
// start high and busy low; busy rises only while the two-entry command queue
// is full. The player handles a note write, a score enqueue or a direct play
// in its idle state, as it does a tick that only loads the next score or
// rewinds the score queue; a tick that reads the current note goes on to
// ST_FIRST, where it either keeps playing it or ends the score, and one whose
// note has run out goes on to ST_SECOND to fetch the next note, because every
// note comes out of a note memory with a registered read port. Each result
// appears on result for exactly one cycle, marked by result_valid, starting
// the cycle after the player finishes the item; the receiver cannot stall it,
// so capture it on that edge. Note writes, score enqueues, empty scores and
// ticks while tick_step is zero give no result. Write tick_step only while idle.
module beeper_melody_sequencer_unit #(
    parameter int SCORE_SLOTS = 8,
    parameter int NOTE_DEPTH  = 256
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  bms_pkg::item_t   cmd,
    output logic             result_valid,
    output bms_pkg::result_t result,
    input  logic             cfg_wr_en,
    input  logic [15:0]      cfg_wr_data
);
    import bms_pkg::*;

    logic [15:0] tick_step_reg;
    logic        push;
    cmd_t        push_cmd;
    cmd_t        head;
    logic        pop;
    logic        queue_full;
    logic        queue_empty;

    // Hold the tick step; a zero step parks the player.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tick_step_reg <= '0;
        else if (cfg_wr_en)
            tick_step_reg <= cfg_wr_data;
    end

    // Classify each item and drop the ones that cannot do anything.
    bms_front u_front (
        .start      (start),
        .cmd        (cmd),
        .tick_step  (tick_step_reg),
        .queue_full (queue_full),
        .busy       (busy),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    // Decouple acceptance from the player's multi-cycle ticks.
    bms_cmd_fifo u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .full     (queue_full),
        .empty    (queue_empty)
    );

    // Carry out one command at a time and drive the result strobe.
    bms_player #(
        .SCORE_SLOTS (SCORE_SLOTS),
        .NOTE_DEPTH  (NOTE_DEPTH)
    ) u_player (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick_step    (tick_step_reg),
        .head         (head),
        .empty        (queue_empty),
        .pop          (pop),
        .result_valid (result_valid),
        .result       (result)
    );

    // Never push into a full queue: items would be lost.
    assert property (@(posedge clk) disable iff (!rst_n) push |-> !queue_full)
        else $error("push into full command queue");

    // Every push comes from an accepted item.
    assert property (@(posedge clk) disable iff (!rst_n) push |-> (start && !busy))
        else $error("push without accepted item");

    // A stop result carries zero tone and gain.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.beeper_on) |->
        (result.out_tone == 16'd0 && result.out_gain == 8'd0))
        else $error("stop result with nonzero payload");

    // Nothing is popped from the command queue while it is empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !queue_empty)
        else $error("pop from empty command queue");

endmodule
